FILE: rtl/s1sh_pkg.sv
// Package for the streaming SHA-1 hasher: hash constants, round constants and the
// control structures passed between the sequencer, the schedule line and the round unit.
// No dependencies.
`default_nettype none

package s1sh_pkg;

    localparam int WORD_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int N_WORDS  = 5;
    localparam int SCHED_N  = 16;
    localparam int LEN_W    = 64;
    localparam int FILL_W   = 6;
    localparam int RND_W    = 7;
    localparam int IDX_W    = 3;

    typedef logic [0:N_WORDS-1][WORD_W-1:0] t_hash;

    localparam t_hash H_INIT = {
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [WORD_W-1:0] K_0 = 32'h5A827999;
    localparam logic [WORD_W-1:0] K_1 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K_2 = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K_3 = 32'hCA62C1D6;

    localparam logic [BYTE_W-1:0] PAD_BYTE   = 8'h80;
    localparam logic [FILL_W-1:0] LEN_POS    = 6'd56;
    localparam logic [FILL_W-1:0] FILL_LAST  = 6'd63;
    localparam logic [RND_W-1:0]  RND_LAST   = 7'd79;
    localparam logic [RND_W-1:0]  RND_PHASE1 = 7'd20;
    localparam logic [RND_W-1:0]  RND_PHASE2 = 7'd40;
    localparam logic [RND_W-1:0]  RND_PHASE3 = 7'd60;
    localparam logic [IDX_W-1:0]  IDX_LAST   = 3'd4;
    localparam logic [LEN_W-1:0]  BITS_PER_BYTE = 64'd8;

    // Controls for the round unit.
    typedef struct packed {
        logic init;   // return the chaining words to their initial values
        logic load;   // copy chaining words into the working variables
        logic rnd;    // perform one round
        logic add;    // fold the working variables into the chaining words
    } t_core_ctl;

    // Controls for the message schedule line.
    typedef struct packed {
        logic ins;    // shift one byte into the block
        logic rnd;    // advance the schedule by one word
    } t_sched_ctl;

endpackage

`default_nettype wire

FILE: rtl/s1sh_if.sv
// Handshake interfaces for the streaming SHA-1 hasher: byte input channel and digest
// output channel. No dependencies.
`default_nettype none

interface s1sh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       finish;

    modport source (output valid, output data_byte, output byte_present, output finish,
                    input ready);
    modport sink   (input valid, input data_byte, input byte_present, input finish,
                    output ready);
endinterface

interface s1sh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index, output last_word,
                    input ready);
    modport sink   (input valid, input digest_word, input word_index, input last_word,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/s1sh_sched.sv
// Block buffer and message schedule for the SHA-1 hasher: a sixteen-word shift line
// that takes bytes in and then expands the schedule one word per round. Uses s1sh_pkg.
`default_nettype none

module s1sh_sched (
    input  wire                                i_clk,
    input  s1sh_pkg::t_sched_ctl               i_ctl,
    input  wire  [s1sh_pkg::BYTE_W-1:0]        i_byte,
    output logic [s1sh_pkg::WORD_W-1:0]        o_w
);

    logic [s1sh_pkg::WORD_W-1:0] r_w [s1sh_pkg::SCHED_N];
    logic [s1sh_pkg::WORD_W-1:0] n_x;
    logic [s1sh_pkg::WORD_W-1:0] n_new;

    // W[t+16] = rotl1(W[t+13] ^ W[t+8] ^ W[t+2] ^ W[t]).
    always_comb begin
        n_x   = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        n_new = {n_x[s1sh_pkg::WORD_W-2:0], n_x[s1sh_pkg::WORD_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            for (int i = 0; i < s1sh_pkg::SCHED_N - 1; i++) begin
                r_w[i] <= {r_w[i][23:0], r_w[i+1][31:24]};
            end
            r_w[s1sh_pkg::SCHED_N-1] <= {r_w[s1sh_pkg::SCHED_N-1][23:0], i_byte};
        end else if (i_ctl.rnd) begin
            for (int i = 0; i < s1sh_pkg::SCHED_N - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[s1sh_pkg::SCHED_N-1] <= n_new;
        end
    end

    assign o_w = r_w[0];

endmodule

`default_nettype wire

FILE: rtl/s1sh_round.sv
// Shared SHA-1 round unit with the chaining words: one round per cycle, then a fold of
// the working variables into the chaining words. Uses s1sh_pkg.
`default_nettype none

module s1sh_round (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  s1sh_pkg::t_core_ctl                i_ctl,
    input  wire  [s1sh_pkg::RND_W-1:0]         i_rnd,
    input  wire  [s1sh_pkg::WORD_W-1:0]        i_w,
    output s1sh_pkg::t_hash                    o_h
);

    s1sh_pkg::t_hash             r_h;
    logic [s1sh_pkg::WORD_W-1:0] r_a, r_b, r_c, r_d, r_e;
    logic [s1sh_pkg::WORD_W-1:0] n_f, n_k, n_t;

    always_comb begin
        priority if (i_rnd < s1sh_pkg::RND_PHASE1) begin
            n_f = (r_b & r_c) | (~r_b & r_d);
            n_k = s1sh_pkg::K_0;
        end else if (i_rnd < s1sh_pkg::RND_PHASE2) begin
            n_f = r_b ^ r_c ^ r_d;
            n_k = s1sh_pkg::K_1;
        end else if (i_rnd < s1sh_pkg::RND_PHASE3) begin
            n_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            n_k = s1sh_pkg::K_2;
        end else begin
            n_f = r_b ^ r_c ^ r_d;
            n_k = s1sh_pkg::K_3;
        end
        n_t = {r_a[26:0], r_a[31:27]} + n_f + r_e + i_w + n_k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h <= s1sh_pkg::H_INIT;
        end else if (i_ctl.init) begin
            r_h <= s1sh_pkg::H_INIT;
        end else if (i_ctl.add) begin
            r_h[0] <= r_h[0] + r_a;
            r_h[1] <= r_h[1] + r_b;
            r_h[2] <= r_h[2] + r_c;
            r_h[3] <= r_h[3] + r_d;
            r_h[4] <= r_h[4] + r_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (i_ctl.rnd) begin
            r_a <= n_t;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    assign o_h = r_h;

endmodule

`default_nettype wire

FILE: rtl/sha1_stream_hasher_unit.sv
// Streaming SHA-1 hasher, top level. Depends on s1sh_pkg, s1sh_if, s1sh_sched, s1sh_round.
// Operation: each byte transaction is taken in the idle state; every 64th byte adds a
// compression (load, 80 rounds on the single round unit, fold). A finish runs the padding
// one byte per cycle (with up to two compressions); then five digest transactions follow,
// one per cycle while the receiver holds ready.
// Reset (synchronous, active low) restores the initial chaining words and clears counts.
`default_nettype none

module sha1_stream_hasher_unit (
    input  wire             i_clk,
    input  wire             i_rst_n,
    s1sh_in_if.sink         i_in,
    s1sh_out_if.source      o_out
);

    // The sequencer walks through these states. Only the idle state takes input
    // transactions, and only the output state offers digest words.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_state;

    t_state                        r_state;
    logic [s1sh_pkg::FILL_W-1:0]   r_fill;
    logic [s1sh_pkg::LEN_W-1:0]    r_len;
    logic                          r_done;
    logic                          r_fin_pend;
    logic                          r_padding;
    logic                          r_pad_first;
    logic                          r_len_phase;
    logic [s1sh_pkg::RND_W-1:0]    r_rnd;
    logic [s1sh_pkg::IDX_W-1:0]    r_widx;

    s1sh_pkg::t_core_ctl           core_ctl;
    s1sh_pkg::t_sched_ctl          sched_ctl;
    s1sh_pkg::t_hash               hash;
    logic [s1sh_pkg::WORD_W-1:0]   sched_w;
    logic [s1sh_pkg::BYTE_W-1:0]   ins_byte;
    logic [s1sh_pkg::BYTE_W-1:0]   pad_byte;
    logic [s1sh_pkg::BYTE_W-1:0]   len_byte;
    logic                          in_acc;
    logic [s1sh_pkg::FILL_W-1:0]   fill_eff;
    logic [s1sh_pkg::LEN_W-1:0]    len_eff;

    assign in_acc = i_in.valid && i_in.ready;

    // Once a digest has been produced, the next byte starts a fresh message, so the
    // byte count and length are taken as zero for that transaction.
    assign fill_eff = r_done ? '0 : r_fill;
    assign len_eff  = r_done ? '0 : r_len;

    // The length goes into the last eight bytes of the final block, most significant
    // byte first; the low three bits of the fill select which byte is due.
    assign len_byte = s1sh_pkg::BYTE_W'(r_len >> {~r_fill[2:0], 3'b000});

    // The padding stream is the marker byte, zeros, and then the length once the final
    // block has been reached.
    always_comb begin
        priority if (r_pad_first) begin
            pad_byte = s1sh_pkg::PAD_BYTE;
        end else if (r_len_phase && (r_fill >= s1sh_pkg::LEN_POS)) begin
            pad_byte = len_byte;
        end else begin
            pad_byte = '0;
        end
    end

    assign ins_byte = (r_state == ST_PAD) ? pad_byte : i_in.data_byte;

    // Controls for the schedule line and the round unit are decoded from the state.
    always_comb begin
        core_ctl  = '0;
        sched_ctl = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && i_in.byte_present) begin
                    core_ctl.init = r_done;
                    sched_ctl.ins = 1'b1;
                end
            end
            ST_PAD: begin
                sched_ctl.ins = 1'b1;
            end
            ST_LOAD: begin
                core_ctl.load = 1'b1;
            end
            ST_ROUND: begin
                core_ctl.rnd  = 1'b1;
                sched_ctl.rnd = 1'b1;
            end
            ST_ADD: begin
                core_ctl.add = 1'b1;
            end
            ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_len       <= '0;
            r_done      <= 1'b0;
            r_fin_pend  <= 1'b0;
            r_padding   <= 1'b0;
            r_pad_first <= 1'b0;
            r_len_phase <= 1'b0;
            r_rnd       <= '0;
            r_widx      <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_fin_pend  <= i_in.finish;
                        r_padding   <= 1'b0;
                        r_pad_first <= 1'b1;
                        r_widx      <= '0;
                        if (i_in.byte_present) begin
                            r_fill <= fill_eff + 1'b1;
                            r_len  <= len_eff + s1sh_pkg::BITS_PER_BYTE;
                            r_done <= 1'b0;
                        end
                        priority if (i_in.byte_present && fill_eff == s1sh_pkg::FILL_LAST) begin
                            r_state <= ST_LOAD;
                        end else if (i_in.finish) begin
                            // A finish with no new byte after a digest re-emits it.
                            r_state <= (r_done && !i_in.byte_present) ? ST_OUT : ST_PAD;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_PAD: begin
                    r_fill      <= r_fill + 1'b1;
                    r_padding   <= 1'b1;
                    r_pad_first <= 1'b0;
                    // If the marker lands before the length field, this block is the last.
                    if (r_pad_first) begin
                        r_len_phase <= (r_fill < s1sh_pkg::LEN_POS);
                    end
                    if (r_fill == s1sh_pkg::FILL_LAST) begin
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_rnd   <= '0;
                    r_state <= ST_ROUND;
                end
                ST_ROUND: begin
                    r_rnd <= r_rnd + 1'b1;
                    if (r_rnd == s1sh_pkg::RND_LAST) begin
                        r_state <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    priority if (r_padding && r_len_phase) begin
                        r_done  <= 1'b1;
                        r_len   <= '0;
                        r_fill  <= '0;
                        r_widx  <= '0;
                        r_state <= ST_OUT;
                    end else if (r_padding) begin
                        // The marker spilled into the length field: one more block follows.
                        r_len_phase <= 1'b1;
                        r_state     <= ST_PAD;
                    end else if (r_fin_pend) begin
                        r_state <= ST_PAD;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_OUT: begin
                    if (o_out.ready) begin
                        if (r_widx == s1sh_pkg::IDX_LAST) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_widx <= r_widx + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = (r_state == ST_OUT);
    assign o_out.digest_word = hash[r_widx];
    assign o_out.word_index  = r_widx;
    assign o_out.last_word   = (r_widx == s1sh_pkg::IDX_LAST);

    s1sh_sched u_sched (
        .i_clk  (i_clk),
        .i_ctl  (sched_ctl),
        .i_byte (ins_byte),
        .o_w    (sched_w)
    );

    s1sh_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .i_rnd   (r_rnd),
        .i_w     (sched_w),
        .o_h     (hash)
    );

endmodule

`default_nettype wire

FILE: rtl/s1sh_checker.sv
// Port-level checks for the streaming SHA-1 hasher, attached to the top level by bind.
// Depends on sha1_stream_hasher_unit.
`default_nettype none

module s1sh_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [31:0] i_digest_word,
    input wire [2:0]  i_word_index,
    input wire        i_last_word
);

    // The block never takes input while it offers digest words.
    a_busy_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while digest words are offered");

    // The last flag marks the fifth word and only that one.
    a_last_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_last_word == (i_word_index == 3'd4)))
        else $error("last_word does not match word_index");

    // A taken word that is not the last is followed at once by the next word.
    a_words_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_last_word) |=>
            (i_out_valid && i_word_index == $past(i_word_index) + 3'd1))
        else $error("digest words do not follow in order");

    // A stalled digest word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_digest_word) && $stable(i_word_index)))
        else $error("stalled digest word changed");

endmodule

bind sha1_stream_hasher_unit s1sh_checker u_s1sh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_digest_word (o_out.digest_word),
    .i_word_index  (o_out.word_index),
    .i_last_word   (o_out.last_word)
);

`default_nettype wire

FILE: verif/sha1_hash_checker.sv
// Checker for the streaming SHA-1 hasher. It watches the byte and digest channels,
// predicts every digest word and compares each one as it is taken.
// Depends on s1sh_pkg and the channel interfaces in s1sh_if.
module sha1_hash_checker (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_end_of_test,
    s1sh_in_if   i_in_mon,
    s1sh_out_if  i_out_mon,
    output int   o_pending,
    output int   o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_CAP = 60;

    typedef struct packed {
        logic [s1sh_pkg::WORD_W-1:0] word;
        logic [s1sh_pkg::IDX_W-1:0]  idx;
        logic                        last;
    } t_digest_beat;

    // Own copy of the hashing state.
    logic [s1sh_pkg::WORD_W-1:0] chain_h [s1sh_pkg::N_WORDS];
    logic [s1sh_pkg::BYTE_W-1:0] blk_bytes [64];
    logic [s1sh_pkg::FILL_W-1:0] blk_fill;
    logic [s1sh_pkg::LEN_W-1:0]  msg_bits;
    logic                        digest_ready;

    t_digest_beat digest_fifo [$];
    int           mismatch_count = 0;
    bit           end_checked = 1'b0;

    function automatic logic [s1sh_pkg::WORD_W-1:0] rotl32(
        input logic [s1sh_pkg::WORD_W-1:0] x, input int n);
        return (x << n) | (x >> (s1sh_pkg::WORD_W - n));
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("%0t ns: MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic restart_chain();
        for (int i = 0; i < s1sh_pkg::N_WORDS; i++)
            chain_h[i] = s1sh_pkg::H_INIT[i];
        blk_fill     = '0;
        msg_bits     = '0;
        digest_ready = 1'b0;
    endtask

    task automatic compress_block();
        logic [s1sh_pkg::WORD_W-1:0] w [80];
        logic [s1sh_pkg::WORD_W-1:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        for (int i = 16; i < 80; i++)
            w[i] = rotl32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d);
                k = s1sh_pkg::K_0;
            end else if (i < 40) begin
                f = b ^ c ^ d;
                k = s1sh_pkg::K_1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = s1sh_pkg::K_2;
            end else begin
                f = b ^ c ^ d;
                k = s1sh_pkg::K_3;
            end
            t = rotl32(a, 5) + f + e + w[i] + k;
            e = d;
            d = c;
            c = rotl32(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
        blk_fill = '0;
    endtask

    // Works out the digest words that one byte transaction causes.
    task automatic hash_take_item(input logic [s1sh_pkg::BYTE_W-1:0] data,
                                  input logic present, input logic fin);
        int           pos;
        t_digest_beat beat;
        if (present) begin
            if (digest_ready)
                restart_chain();
            blk_bytes[blk_fill] = data;
            blk_fill = blk_fill + 1'b1;
            msg_bits = msg_bits + s1sh_pkg::BITS_PER_BYTE;
            if (blk_fill == '0)
                compress_block();
        end
        if (fin) begin
            if (!digest_ready) begin
                // Padding: marker byte, zeros, then the big-endian bit count. When the
                // marker lands in the length field, an extra block is needed.
                pos = int'(blk_fill);
                blk_bytes[pos] = s1sh_pkg::PAD_BYTE;
                pos++;
                if (pos > int'(s1sh_pkg::LEN_POS)) begin
                    while (pos < 64) begin
                        blk_bytes[pos] = '0;
                        pos++;
                    end
                    compress_block();
                    pos = 0;
                end
                while (pos < int'(s1sh_pkg::LEN_POS)) begin
                    blk_bytes[pos] = '0;
                    pos++;
                end
                for (int j = 0; j < 8; j++)
                    blk_bytes[int'(s1sh_pkg::LEN_POS) + j] =
                        msg_bits[s1sh_pkg::LEN_W-1-8*j -: 8];
                compress_block();
                for (int i = 0; i < 64; i++)
                    blk_bytes[i] = '0;
                msg_bits     = '0;
                blk_fill     = '0;
                digest_ready = 1'b1;
            end
            for (int i = 0; i < s1sh_pkg::N_WORDS; i++) begin
                beat.word = chain_h[i];
                beat.idx  = s1sh_pkg::IDX_W'(i);
                beat.last = (i == int'(s1sh_pkg::IDX_LAST));
                digest_fifo.push_back(beat);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_digest_beat beat;
        if (!i_rst_n) begin
            restart_chain();
            for (int i = 0; i < 64; i++)
                blk_bytes[i] = '0;
            digest_fifo.delete();
        end else begin
            if (i_in_mon.valid && i_in_mon.ready)
                hash_take_item(i_in_mon.data_byte, i_in_mon.byte_present, i_in_mon.finish);
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (digest_fifo.size() == 0) begin
                    report_mismatch($sformatf("unexpected digest word %h index %0d last %b",
                        i_out_mon.digest_word, i_out_mon.word_index, i_out_mon.last_word));
                end else begin
                    beat = digest_fifo.pop_front();
                    if (i_out_mon.digest_word !== beat.word ||
                        i_out_mon.word_index !== beat.idx ||
                        i_out_mon.last_word !== beat.last)
                        report_mismatch($sformatf(
                            "got word %h index %0d last %b, expected %h index %0d last %b",
                            i_out_mon.digest_word, i_out_mon.word_index,
                            i_out_mon.last_word, beat.word, beat.idx, beat.last));
                end
            end
            if (i_end_of_test && !end_checked) begin
                end_checked = 1'b1;
                if (digest_fifo.size() != 0)
                    report_mismatch($sformatf("%0d digest words never arrived",
                        digest_fifo.size()));
            end
        end
        o_pending <= digest_fifo.size();
        o_errors  <= mismatch_count;
    end

endmodule

FILE: verif/testbench.sv
// Top of the streaming SHA-1 hasher testbench: clock, reset, byte stimulus with random
// idling, a randomly stalling digest receiver, a watchdog and the verdict.
// Depends on s1sh_pkg, s1sh_if, sha1_hash_checker and the block itself.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // A finish can keep both channels quiet while the padding runs through the buffer and up
    // to two compressions take place, and the closing drain is quiet as well. The watchdog
    // limit sits well above both.
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 400;
    localparam int MAX_GAP      = 6;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic end_of_test;

    int pending_words;
    int error_count;
    int items_sent = 0;
    int finishes_sent = 0;

    // When set, the sender offers its transactions back to back for the current message.
    bit tx_eager = 1'b0;

    s1sh_in_if  in_ch ();
    s1sh_out_if out_ch ();

    sha1_stream_hasher_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    sha1_hash_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_end_of_test (end_of_test),
        .i_in_mon      (in_ch),
        .i_out_mon     (out_ch),
        .o_pending     (pending_words),
        .o_errors      (error_count)
    );

    always #2 i_clk = ~i_clk;

    // Offers one byte transaction and returns at the edge at which it is accepted. The
    // valid line is lowered only when a gap is drawn, so that a back-to-back transaction
    // never sees valid fall and rise within the same time step.
    task automatic send_item(input logic [7:0] data, input logic present, input logic fin);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.data_byte    <= data;
        in_ch.byte_present <= present;
        in_ch.finish       <= fin;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        // Every accepted transaction counts towards the length of the run.
        items_sent++;
        if (fin)
            finishes_sent++;
    endtask

    // Holds the sender back until every predicted digest word has been taken. The
    // checker's pending count is registered, hence the edge before the first look.
    task automatic wait_for_digests();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0)
            @(posedge i_clk);
    endtask

    // Digest receiver. The ready line follows stretches of eager acceptance and stretches
    // of random stalls, each stall drawn afresh for every transaction.
    initial begin
        int gap;
        int stretch;
        bit eager;
        out_ch.ready <= 1'b0;
        stretch = 0;
        eager   = 1'b0;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (stretch == 0) begin
                stretch = $urandom_range(4, 24);
                eager   = ($urandom_range(0, 2) == 0);
            end
            stretch--;
            gap = eager ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    // Watchdog: counts cycles in which neither channel completes a transaction.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t ns: watchdog expired with %0d digest words outstanding",
                 $realtime, pending_words);
        $display("DONE: errors detected");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        int  sel;
        int  len;
        bit  fin_with_byte;
        bit  paused;
        logic [7:0] msg [];

        i_rst_n            <= 1'b0;
        end_of_test        <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.data_byte    <= '0;
        in_ch.byte_present <= 1'b0;
        in_ch.finish       <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. A finish on the empty message comes first, then a repeated
        // finish, which must give the same digest with the data lines held high.
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b0, 1'b1);
        // A byte after a digest restarts the hash; here it also carries the finish.
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        // The classic three-letter message, with an ignored transaction in the middle.
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b0);
        send_item(8'h5A, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b0, 1'b1);
        // The sender holds off here until the block has delivered everything.
        wait_for_digests();
        // A restart without a finish on the first byte, then a finish on the last byte.
        tx_eager = 1'b1;
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h7F, 1'b1, 1'b0);
        send_item(8'h01, 1'b1, 1'b0);
        send_item(8'hFE, 1'b1, 1'b1);
        tx_eager = 1'b0;

        // Random part: whole messages of random content. Most are short; a good share sit
        // around one block so that the padding crosses into a second block or the length
        // field just fits; a few span two blocks. Ignored transactions, repeated finishes
        // and messages left open (which then run into the next one) make up the noise.
        // Message lengths are trimmed near the end so that the run stays close to its size.
        paused = 1'b0;
        while (items_sent < 120 || finishes_sent < 12) begin
            sel = $urandom_range(0, 99);
            if (sel < 55)
                len = $urandom_range(0, 10);
            else if (sel < 88)
                len = $urandom_range(52, 70);
            else
                len = $urandom_range(110, 135);
            if (len > 128 - items_sent)
                len = (items_sent < 128) ? 128 - items_sent : 0;
            msg = new[len];
            foreach (msg[i])
                msg[i] = 8'($urandom());
            tx_eager      = ($urandom_range(0, 3) == 0);
            fin_with_byte = ($urandom_range(0, 1) == 1);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 99) < 8)
                    send_item(8'($urandom()), 1'b0, 1'b0);
                send_item(msg[i], 1'b1, (i == len - 1) && fin_with_byte);
            end
            if ($urandom_range(0, 9) != 0) begin
                if (len == 0 || !fin_with_byte)
                    send_item(8'($urandom()), 1'b0, 1'b1);
                if ($urandom_range(0, 99) < 15)
                    send_item(8'($urandom()), 1'b0, 1'b1);
            end
            if (!paused && finishes_sent >= 8) begin
                paused = 1'b1;
                wait_for_digests();
            end
        end

        // End of stimulus: lower valid, let every predicted word arrive, then give the
        // block time to show any stray transaction before the leftover check.
        wait_for_digests();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        end_of_test <= 1'b1;
        repeat (3) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
